[rtl/assert_macros.svh]
// Assertion macros shared by the execute unit RTL.
// Depends on nothing; included inside module bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/rieu_pkg.sv]
// Package for the integer execute unit: operation codes and shared types.
// Depends on nothing.
package rieu_pkg;

    typedef enum logic [5:0] {
        OP_ADD, OP_ADDC, OP_ADDI, OP_ADDV, OP_AND, OP_ANDI, OP_CLRMAC, OP_CLRT,
        OP_CMPEQ, OP_CMPGE, OP_CMPGT, OP_CMPHI, OP_CMPHS, OP_CMPIM, OP_CMPPL, OP_CMPPZ,
        OP_CMPSTR, OP_DIV0S, OP_DIV0U, OP_DIV1, OP_DMULS, OP_DMULU, OP_DT, OP_EXTSB,
        OP_EXTSW, OP_EXTUB, OP_EXTUW, OP_MOV, OP_MOVI, OP_MOVT, OP_MULL, OP_MULS,
        OP_MULU, OP_NEG, OP_NEGC, OP_NOP, OP_NOT, OP_OR, OP_ORI, OP_ROTCL,
        OP_ROTCR, OP_ROTL, OP_ROTR, OP_SETT, OP_SHAL, OP_SHAR, OP_SHLL, OP_SHLL16,
        OP_SHLL2, OP_SHLL8, OP_SHLR, OP_SHLR16, OP_SHLR2, OP_SHLR8, OP_SUB, OP_SUBC,
        OP_SUBV, OP_SWAPB, OP_SWAPW, OP_TST, OP_TSTI, OP_XOR, OP_XORI, OP_XTRCT
    } op_t;

    // Result of one pass through the ALU.
    typedef struct packed {
        logic        wr;
        logic        dest_r0;
        logic [31:0] res;
        logic        t;
        logic        q;
        logic        m;
        logic        mac_hi_wr;
        logic        mac_lo_wr;
        logic [63:0] mac;
    } alu_res_t;

endpackage

[rtl/rieu_alu.sv]
// Combinational integer ALU of the execute unit.
// Depends on rieu_pkg.
module rieu_alu (
    input  rieu_pkg::op_t     op,
    input  logic [31:0]       rn,
    input  logic [31:0]       rm,
    input  logic [31:0]       r0,
    input  logic [7:0]        immediate,
    input  logic              t_in,
    input  logic              q_in,
    input  logic              m_in,
    input  logic [63:0]       mac_in,
    output rieu_pkg::alu_res_t result
);
    import rieu_pkg::*;

    logic [31:0] imm_s;
    logic [31:0] imm_u;
    logic [32:0] sum_c;
    logic [31:0] sum;
    logic [31:0] diff;
    logic [31:0] neg_rm;
    logic [31:0] xr;
    logic [32:0] div_r;
    logic [32:0] div_sh;
    logic        div_q;
    logic [63:0] prod_s;
    logic [63:0] prod_u;
    logic [31:0] prod_l;
    logic [31:0] prod_w;
    logic [31:0] prod_h;

    assign imm_s  = {{24{immediate[7]}}, immediate};
    assign imm_u  = {24'd0, immediate};
    assign sum_c  = {1'b0, rn} + {1'b0, rm} + {32'd0, t_in};
    assign sum    = rn + rm;
    assign diff   = rn - rm;
    assign neg_rm = 32'd0 - rm;
    assign xr     = rn ^ rm;
    assign div_sh = {1'b0, rn[30:0], t_in};
    assign div_r  = (q_in == m_in) ? (div_sh - {1'b0, rm}) : (div_sh + {1'b0, rm});
    assign div_q  = rn[31] ^ m_in ^ div_r[32];
    assign prod_s = $signed(rn) * $signed(rm);
    assign prod_u = rn * rm;
    assign prod_l = prod_u[31:0];
    assign prod_w = $signed(rn[15:0]) * $signed(rm[15:0]);
    assign prod_h = {16'd0, rn[15:0]} * {16'd0, rm[15:0]};

    // Operation decode.
    always_comb
    begin
        result = '{wr: 1'b1, dest_r0: 1'b0, res: rn, t: t_in, q: q_in, m: m_in,
                   mac_hi_wr: 1'b0, mac_lo_wr: 1'b0, mac: mac_in};
        unique case (op) inside
            OP_ADD:    result.res = sum;
            OP_ADDC:   begin result.res = sum_c[31:0]; result.t = sum_c[32]; end
            OP_ADDI:   result.res = rn + imm_s;
            OP_ADDV:
            begin
                result.res = sum;
                result.t = (rn[31] == rm[31]) && (sum[31] != rn[31]);
            end
            OP_AND:    result.res = rn & rm;
            OP_ANDI:   begin result.dest_r0 = 1'b1; result.res = r0 & imm_u; end
            OP_CLRMAC:
            begin
                result.wr = 1'b0; result.mac = 64'd0;
                result.mac_hi_wr = 1'b1; result.mac_lo_wr = 1'b1;
            end
            OP_CLRT:   begin result.wr = 1'b0; result.t = 1'b0; end
            OP_CMPEQ:  begin result.wr = 1'b0; result.t = (rn == rm); end
            OP_CMPGE:  begin result.wr = 1'b0; result.t = ($signed(rn) >= $signed(rm)); end
            OP_CMPGT:  begin result.wr = 1'b0; result.t = ($signed(rn) > $signed(rm)); end
            OP_CMPHI:  begin result.wr = 1'b0; result.t = (rn > rm); end
            OP_CMPHS:  begin result.wr = 1'b0; result.t = (rn >= rm); end
            OP_CMPIM:
            begin
                result.wr = 1'b0; result.dest_r0 = 1'b1; result.t = (r0 == imm_s);
            end
            OP_CMPPL:  begin result.wr = 1'b0; result.t = ($signed(rn) > 0); end
            OP_CMPPZ:  begin result.wr = 1'b0; result.t = !rn[31]; end
            OP_CMPSTR:
            begin
                result.wr = 1'b0;
                result.t = (xr[7:0] == 8'd0) || (xr[15:8] == 8'd0) ||
                           (xr[23:16] == 8'd0) || (xr[31:24] == 8'd0);
            end
            OP_DIV0S:
            begin
                result.wr = 1'b0; result.q = rn[31]; result.m = rm[31];
                result.t = rn[31] ^ rm[31];
            end
            OP_DIV0U:
            begin
                result.wr = 1'b0; result.q = 1'b0; result.m = 1'b0; result.t = 1'b0;
            end
            OP_DIV1:
            begin
                result.res = div_r[31:0]; result.q = div_q; result.t = !(div_q ^ m_in);
            end
            OP_DMULS:
            begin
                result.wr = 1'b0; result.mac = prod_s;
                result.mac_hi_wr = 1'b1; result.mac_lo_wr = 1'b1;
            end
            OP_DMULU:
            begin
                result.wr = 1'b0; result.mac = prod_u;
                result.mac_hi_wr = 1'b1; result.mac_lo_wr = 1'b1;
            end
            OP_DT:     begin result.res = rn - 32'd1; result.t = (rn == 32'd1); end
            OP_EXTSB:  result.res = {{24{rm[7]}}, rm[7:0]};
            OP_EXTSW:  result.res = {{16{rm[15]}}, rm[15:0]};
            OP_EXTUB:  result.res = {24'd0, rm[7:0]};
            OP_EXTUW:  result.res = {16'd0, rm[15:0]};
            OP_MOV:    result.res = rm;
            OP_MOVI:   result.res = imm_s;
            OP_MOVT:   result.res = {31'd0, t_in};
            OP_MULL:
            begin
                result.wr = 1'b0; result.mac = {32'd0, prod_l}; result.mac_lo_wr = 1'b1;
            end
            OP_MULS:
            begin
                result.wr = 1'b0; result.mac = {32'd0, prod_w}; result.mac_lo_wr = 1'b1;
            end
            OP_MULU:
            begin
                result.wr = 1'b0; result.mac = {32'd0, prod_h};
                result.mac_lo_wr = 1'b1;
            end
            OP_NEG:    result.res = neg_rm;
            OP_NEGC:
            begin
                result.res = neg_rm - {31'd0, t_in};
                result.t = (neg_rm != 32'd0) || t_in;
            end
            OP_NOP:    result.wr = 1'b0;
            OP_NOT:    result.res = ~rm;
            OP_OR:     result.res = rn | rm;
            OP_ORI:    begin result.dest_r0 = 1'b1; result.res = r0 | imm_u; end
            OP_ROTCL:  begin result.res = {rn[30:0], t_in}; result.t = rn[31]; end
            OP_ROTCR:  begin result.res = {t_in, rn[31:1]}; result.t = rn[0]; end
            OP_ROTL:   begin result.res = {rn[30:0], rn[31]}; result.t = rn[31]; end
            OP_ROTR:   begin result.res = {rn[0], rn[31:1]}; result.t = rn[0]; end
            OP_SETT:   begin result.wr = 1'b0; result.t = 1'b1; end
            OP_SHAL, OP_SHLL:
            begin
                result.res = {rn[30:0], 1'b0}; result.t = rn[31];
            end
            OP_SHAR:   begin result.res = {rn[31], rn[31:1]}; result.t = rn[0]; end
            OP_SHLL16: result.res = {rn[15:0], 16'd0};
            OP_SHLL2:  result.res = {rn[29:0], 2'd0};
            OP_SHLL8:  result.res = {rn[23:0], 8'd0};
            OP_SHLR:   begin result.res = {1'b0, rn[31:1]}; result.t = rn[0]; end
            OP_SHLR16: result.res = {16'd0, rn[31:16]};
            OP_SHLR2:  result.res = {2'd0, rn[31:2]};
            OP_SHLR8:  result.res = {8'd0, rn[31:8]};
            OP_SUB:    result.res = diff;
            OP_SUBC:
            begin
                result.res = diff - {31'd0, t_in};
                result.t = (rn < diff) || (diff < (diff - {31'd0, t_in}));
            end
            OP_SUBV:
            begin
                result.res = diff;
                result.t = (rn[31] != rm[31]) && (diff[31] != rn[31]);
            end
            OP_SWAPB:  result.res = {rm[31:16], rm[7:0], rm[15:8]};
            OP_SWAPW:  result.res = {rm[15:0], rm[31:16]};
            OP_TST:    begin result.wr = 1'b0; result.t = ((rn & rm) == 32'd0); end
            OP_TSTI:
            begin
                result.wr = 1'b0; result.dest_r0 = 1'b1;
                result.t = ((r0 & imm_u) == 32'd0);
            end
            OP_XOR:    result.res = xr;
            OP_XORI:   begin result.dest_r0 = 1'b1; result.res = r0 ^ imm_u; end
            OP_XTRCT:  result.res = {rm[15:0], rn[31:16]};
            default:   result.wr = 1'b0;
        endcase
        if (!result.wr)
        begin
            result.res = result.dest_r0 ? r0 : rn;
        end
    end

endmodule

[rtl/risc_integer_execute_unit_top.sv]
// Top level of the integer execute unit: register file, flags, MAC, output register.
// Depends on rieu_pkg, rieu_alu and assert_macros.svh.
//
// One instruction per transaction, one transaction per cycle sustained while results
// are drained. An accepted instruction reads the register file, runs through the
// combinational ALU and commits its register, flag and MAC updates at the edge that
// also loads its result into the output register. The next instruction in the
// following cycle sees the committed state. Input ready stays high while the output
// register is empty or being drained, so the only stall comes from the consumer.
module risc_integer_execute_unit_top #(
    parameter int REG_COUNT = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [5:0]  mode,
    input  logic [3:0]  rm_index,
    input  logic [3:0]  rn_index,
    input  logic [7:0]  immediate,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] dest_value,
    output logic        t_out,
    output logic        q_out,
    output logic        m_out,
    output logic [63:0] mac_out
);
    import rieu_pkg::*;

    localparam int IW = $clog2(REG_COUNT);

    logic [31:0]   regs_reg [REG_COUNT];
    logic          t_reg;
    logic          q_reg;
    logic          m_reg;
    logic [63:0]   mac_reg;
    logic          out_valid_reg;
    logic [31:0]   dest_reg;
    logic [IW-1:0] dest_idx;
    logic          accept;
    alu_res_t      alu;
    logic [63:0]   mac_next;

    assign accept   = in_valid && in_ready;
    assign in_ready = !out_valid_reg || out_ready;
    assign dest_idx = alu.dest_r0 ? IW'(0) : rn_index[IW-1:0];

    // Execute the instruction against the current state.
    rieu_alu u_alu (
        .op        (op_t'(mode)),
        .rn        (regs_reg[rn_index[IW-1:0]]),
        .rm        (regs_reg[rm_index[IW-1:0]]),
        .r0        (regs_reg[0]),
        .immediate (immediate),
        .t_in      (t_reg),
        .q_in      (q_reg),
        .m_in      (m_reg),
        .mac_in    (mac_reg),
        .result    (alu)
    );

    assign mac_next = {alu.mac_hi_wr ? alu.mac[63:32] : mac_reg[63:32],
                       alu.mac_lo_wr ? alu.mac[31:0] : mac_reg[31:0]};

    // Architectural state commit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REG_COUNT; i++)
            begin
                regs_reg[i] <= 32'd0;
            end
            t_reg   <= 1'b0;
            q_reg   <= 1'b0;
            m_reg   <= 1'b0;
            mac_reg <= 64'd0;
        end
        else if (accept)
        begin
            if (alu.wr)
            begin
                regs_reg[dest_idx] <= alu.res;
            end
            t_reg   <= alu.t;
            q_reg   <= alu.q;
            m_reg   <= alu.m;
            mac_reg <= mac_next;
        end
    end

    // Output register valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= accept;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            dest_reg <= alu.res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign dest_value = dest_reg;
    assign t_out      = t_reg;
    assign q_out      = q_reg;
    assign m_out      = m_reg;
    assign mac_out    = mac_reg;

`include "assert_macros.svh"

    `ASSERT_IMPLIES(a_stall_blocks_input, clk, rst_n, out_valid_reg && !out_ready, !in_ready)
    `ASSERT_NEXT(a_accept_gives_result, clk, rst_n, accept, out_valid_reg)
    `ASSERT_NEXT(a_flags_hold_idle, clk, rst_n, !accept, $stable(t_reg) && $stable(mac_reg))

endmodule

[bench/risc_integer_execute_unit_top_test.sv]
// Testbench for the integer execute unit: directed and random instruction streams,
// checked against an in-bench model of registers, flags and MAC.
// Depends on rieu_pkg and risc_integer_execute_unit_top.
`timescale 1ns / 100ps

module risc_integer_execute_unit_top_test;
    import rieu_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        logic [31:0] dest;
        logic        t;
        logic        q;
        logic        m;
        logic [63:0] mac;
    } exec_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [5:0]  mode = '0;
    logic [3:0]  rm_index = '0;
    logic [3:0]  rn_index = '0;
    logic [7:0]  immediate = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] dest_value;
    logic        t_out;
    logic        q_out;
    logic        m_out;
    logic [63:0] mac_out;

    // Model state of the execute unit.
    logic [31:0] arch_regs [16];
    logic        arch_t;
    logic        arch_q;
    logic        arch_m;
    logic [63:0] arch_mac;

    exec_result_t pending_results [$];
    int error_count = 0;
    int idle_cycles = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    always #2 clk = ~clk;

    risc_integer_execute_unit_top uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .mode(mode), .rm_index(rm_index), .rn_index(rn_index), .immediate(immediate),
        .out_valid(out_valid), .out_ready(out_ready),
        .dest_value(dest_value), .t_out(t_out), .q_out(q_out), .m_out(m_out),
        .mac_out(mac_out)
    );

    function automatic logic [31:0] sext8(logic [7:0] v);
        return {{24{v[7]}}, v};
    endfunction

    function automatic logic [31:0] sext16(logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    // Executes one instruction on the model state and returns the visible result.
    function automatic exec_result_t execute_instr(op_t op, logic [3:0] mi, logic [3:0] ni,
                                                   logic [7:0] imm);
        logic [31:0] rm, rn, r0, res, tmp, b;
        logic [32:0] wide;
        logic [3:0]  dst;
        logic        wr, t, nq;
        logic [7:0]  x0, x1, x2, x3;
        exec_result_t r;
        rm = arch_regs[mi];
        rn = arch_regs[ni];
        r0 = arch_regs[0];
        dst = ni;
        res = rn;
        wr = 1'b1;
        t = arch_t;
        case (op) inside
            OP_ADD:    res = rn + rm;
            OP_ADDC:   begin wide = {1'b0, rn} + {1'b0, rm} + t; res = wide[31:0]; t = wide[32]; end
            OP_ADDI:   res = rn + sext8(imm);
            OP_ADDV:   begin res = rn + rm; t = (rn[31] == rm[31]) && (res[31] != rn[31]); end
            OP_AND:    res = rn & rm;
            OP_ANDI:   begin dst = 0; res = r0 & {24'd0, imm}; end
            OP_CLRMAC: begin wr = 0; arch_mac = '0; end
            OP_CLRT:   begin wr = 0; t = 0; end
            OP_CMPEQ:  begin wr = 0; t = (rn == rm); end
            OP_CMPGE:  begin wr = 0; t = ($signed(rn) >= $signed(rm)); end
            OP_CMPGT:  begin wr = 0; t = ($signed(rn) > $signed(rm)); end
            OP_CMPHI:  begin wr = 0; t = (rn > rm); end
            OP_CMPHS:  begin wr = 0; t = (rn >= rm); end
            OP_CMPIM:  begin wr = 0; dst = 0; res = r0; t = (r0 == sext8(imm)); end
            OP_CMPPL:  begin wr = 0; t = ($signed(rn) > 0); end
            OP_CMPPZ:  begin wr = 0; t = ($signed(rn) >= 0); end
            OP_CMPSTR:
            begin
                wr = 0;
                {x3, x2, x1, x0} = rn ^ rm;
                t = (x0 == 0) || (x1 == 0) || (x2 == 0) || (x3 == 0);
            end
            OP_DIV0S:  begin wr = 0; arch_q = rn[31]; arch_m = rm[31]; t = rn[31] ^ rm[31]; end
            OP_DIV0U:  begin wr = 0; arch_q = 0; arch_m = 0; t = 0; end
            OP_DIV1:
            begin
                // One non-restoring divide step; the carry folds into Q.
                if (arch_q == arch_m) wide = {1'b0, rn[30:0], t} - {1'b0, rm};
                else wide = {1'b0, rn[30:0], t} + {1'b0, rm};
                res = wide[31:0];
                nq = rn[31] ^ arch_m ^ wide[32];
                arch_q = nq;
                t = ~(nq ^ arch_m);
            end
            OP_DMULS:  begin wr = 0; arch_mac = $signed(rn) * $signed(rm); end
            OP_DMULU:  begin wr = 0; arch_mac = {32'd0, rn} * {32'd0, rm}; end
            OP_DT:     begin res = rn - 1; t = (res == 0); end
            OP_EXTSB:  res = sext8(rm[7:0]);
            OP_EXTSW:  res = sext16(rm[15:0]);
            OP_EXTUB:  res = {24'd0, rm[7:0]};
            OP_EXTUW:  res = {16'd0, rm[15:0]};
            OP_MOV:    res = rm;
            OP_MOVI:   res = sext8(imm);
            OP_MOVT:   res = {31'd0, t};
            OP_MULL:   begin wr = 0; arch_mac[31:0] = rn * rm; end
            OP_MULS:   begin wr = 0; arch_mac[31:0] = sext16(rn[15:0]) * sext16(rm[15:0]); end
            OP_MULU:   begin wr = 0; arch_mac[31:0] = {16'd0, rn[15:0]} * {16'd0, rm[15:0]}; end
            OP_NEG:    res = 0 - rm;
            OP_NEGC:   begin tmp = 0 - rm; res = tmp - t; t = (tmp != 0) || (tmp < res); end
            OP_NOP:    wr = 0;
            OP_NOT:    res = ~rm;
            OP_OR:     res = rn | rm;
            OP_ORI:    begin dst = 0; res = r0 | {24'd0, imm}; end
            OP_ROTCL:  begin res = {rn[30:0], t}; t = rn[31]; end
            OP_ROTCR:  begin res = {t, rn[31:1]}; t = rn[0]; end
            OP_ROTL:   begin res = {rn[30:0], rn[31]}; t = rn[31]; end
            OP_ROTR:   begin res = {rn[0], rn[31:1]}; t = rn[0]; end
            OP_SETT:   begin wr = 0; t = 1; end
            OP_SHAL,
            OP_SHLL:   begin res = {rn[30:0], 1'b0}; t = rn[31]; end
            OP_SHAR:   begin res = {rn[31], rn[31:1]}; t = rn[0]; end
            OP_SHLL16: res = rn << 16;
            OP_SHLL2:  res = rn << 2;
            OP_SHLL8:  res = rn << 8;
            OP_SHLR:   begin res = rn >> 1; t = rn[0]; end
            OP_SHLR16: res = rn >> 16;
            OP_SHLR2:  res = rn >> 2;
            OP_SHLR8:  res = rn >> 8;
            OP_SUB:    res = rn - rm;
            OP_SUBC:   begin b = rn - rm; res = b - t; t = (rn < b) || (b < res); end
            OP_SUBV:
            begin
                res = rn - rm;
                t = (rn[31] != rm[31]) && (res[31] != rn[31]);
            end
            OP_SWAPB:  res = {rm[31:16], rm[7:0], rm[15:8]};
            OP_SWAPW:  res = {rm[15:0], rm[31:16]};
            OP_TST:    begin wr = 0; t = ((rn & rm) == 0); end
            OP_TSTI:   begin wr = 0; dst = 0; res = r0; t = ((r0 & {24'd0, imm}) == 0); end
            OP_XOR:    res = rn ^ rm;
            OP_XORI:   begin dst = 0; res = r0 ^ {24'd0, imm}; end
            default:   res = {rm[15:0], rn[31:16]};
        endcase
        if (wr) arch_regs[dst] = res;
        arch_t = t;
        r.dest = arch_regs[dst];
        r.t = arch_t;
        r.q = arch_q;
        r.m = arch_m;
        r.mac = arch_mac;
        return r;
    endfunction

    // Sends one instruction, with a random idle gap before it. Valid stays high after
    // the accepting edge so that transactions can follow back to back.
    task automatic send_instr(op_t op, logic [3:0] mi, logic [3:0] ni, logic [7:0] imm);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= op;
        rm_index <= mi;
        rn_index <= ni;
        immediate <= imm;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_results.push_back(execute_instr(op, mi, ni, imm));
    endtask

    task automatic send_random(int n, int op_lo, int op_hi);
        repeat (n)
            send_instr(op_t'($urandom_range(op_hi, op_lo)), 4'($urandom), 4'($urandom),
                       8'($urandom));
    endtask

    // Drops valid and waits until every expected result has come back.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Receiver stalls at random.
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    // Compares each result transaction with the oldest expectation.
    always @(posedge clk)
    begin
        exec_result_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result transaction with nothing expected");
                error_count++;
            end
            else
            begin
                e = pending_results.pop_front();
                if (dest_value !== e.dest)
                begin
                    $error("dest_value expected %h actual %h", e.dest, dest_value);
                    error_count++;
                end
                if (t_out !== e.t)
                begin
                    $error("t_out expected %b actual %b", e.t, t_out);
                    error_count++;
                end
                if (q_out !== e.q)
                begin
                    $error("q_out expected %b actual %b", e.q, q_out);
                    error_count++;
                end
                if (m_out !== e.m)
                begin
                    $error("m_out expected %b actual %b", e.m, m_out);
                    error_count++;
                end
                if (mac_out !== e.mac)
                begin
                    $error("mac_out expected %h actual %h", e.mac, mac_out);
                    error_count++;
                end
            end
        end
    end

    // Watchdog over cycles without any accepted transaction.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Loads registers with extreme values, then runs every operation once.
    task automatic test_directed();
        send_instr(OP_MOVI, 0, 1, 8'h7F);
        send_instr(OP_MOVI, 0, 2, 8'h80);
        send_instr(OP_SHLL16, 0, 2, 0);
        send_instr(OP_SHLL8, 0, 2, 0);
        send_instr(OP_MOVI, 0, 3, 8'hFF);
        send_instr(OP_ADDV, 1, 1, 0);
        send_instr(OP_SUBV, 1, 2, 0);
        send_instr(OP_ADDC, 3, 3, 0);
        send_instr(OP_NEGC, 3, 4, 0);
        send_instr(OP_CMPSTR, 3, 2, 0);
        send_instr(OP_DIV0S, 2, 3, 0);
        send_instr(OP_DIV1, 1, 3, 0);
        send_instr(OP_DMULS, 3, 2, 0);
        send_instr(OP_MULL, 1, 3, 0);
        send_instr(OP_MOVI, 0, 15, 8'hFF);
        for (int op = 0; op < 64; op++)
            send_instr(op_t'(op), 4'($urandom), 4'($urandom), 8'($urandom));
    endtask

    // Random streams; DIV0U/DIV0S followed by runs of DIV1 exercise the divider.
    task automatic test_random(int n);
        repeat (n / 20)
        begin
            send_random(10, 0, 63);
            send_instr($urandom_range(1) ? OP_DIV0U : OP_DIV0S, 4'($urandom), 4'($urandom), 0);
            send_random(9, OP_DIV1, OP_DIV1);
        end
    endtask

    // Sender holds off until all results are back, then resumes.
    task automatic test_pause();
        send_random(20, 0, 63);
        wait_drained();
        send_random(20, 0, 63);
    endtask

    initial
    begin
        foreach (arch_regs[i]) arch_regs[i] = '0;
        arch_t = 0;
        arch_q = 0;
        arch_m = 0;
        arch_mac = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_idle_pct = 24;
        recv_stall_pct = 82;
        test_directed();
        test_random(200);
        send_idle_pct = 82;
        recv_stall_pct = 24;
        test_pause();
        test_random(200);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_random(200);
        wait_drained();
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
